>>> design/salc_pkg.sv
`timescale 1ns / 1ps
package salc_pkg;
    localparam int WAYS = 4;
    localparam int SETS = 1024;
    localparam int LINE_BYTES = 32;
    localparam int ADDRESS_BITS = 32;
    localparam int WAY_W = $clog2(WAYS);
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = ADDRESS_BITS - OFF_W - SET_W;
    localparam int PEN_W = 10;
    localparam int COST_W = 11;
    localparam int CNT_W = 32;
    localparam logic [PEN_W-1:0] PENALTY_RESET = PEN_W'(50);
    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [SET_W-1:0] t_set;
    typedef logic [WAY_W-1:0] t_way;

    typedef struct packed {
        logic is_write;
        t_set set_idx;
        t_tag tag;
    } t_req;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction
endpackage

>>> design/salc_if.sv
`timescale 1ns / 1ps
interface salc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] address;
    modport source (output valid, command, address, input ready);
    modport sink (input valid, command, address, output ready);
endinterface

interface salc_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [1:0]  way;
    logic        victim_dirty;
    logic        victim_valid;
    logic [10:0] access_cycles;
    logic [31:0] total_cycles;
    logic [31:0] read_hit_count;
    logic [31:0] read_miss_count;
    logic [31:0] write_hit_count;
    logic [31:0] write_miss_count;
    logic [31:0] writeback_count;
    logic [31:0] eviction_count;
    modport source (output valid, hit, way, victim_dirty, victim_valid, access_cycles,
        total_cycles, read_hit_count, read_miss_count, write_hit_count, write_miss_count,
        writeback_count, eviction_count, input ready);
    modport sink (input valid, hit, way, victim_dirty, victim_valid, access_cycles,
        total_cycles, read_hit_count, read_miss_count, write_hit_count, write_miss_count,
        writeback_count, eviction_count, output ready);
endinterface

interface salc_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> design/salc_front.sv
`timescale 1ns / 1ps
module salc_front
    import salc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    salc_in_if.sink in_ch,
    output logic   o_req_valid,
    output t_req   o_req,
    input  logic   i_req_ready
);
    t_req r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [ADDRESS_BITS-1:0] addr;
    logic push, pop;

    assign addr = in_ch.address;
    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req = r_q[r_rp];
    assign pop = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].is_write <= in_ch.command;
            r_q[r_wp].set_idx <= addr[OFF_W +: SET_W];
            r_q[r_wp].tag <= addr[ADDRESS_BITS-1 -: TAG_W];
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> design/salc_back.sv
`timescale 1ns / 1ps
module salc_back
    import salc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_req    i_req,
    output logic    o_req_ready,
    salc_cfg_if.sink cfg_ch,
    salc_out_if.source out_ch
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    typedef struct packed {
        logic valid;
        logic dirty;
        t_way age;
        t_tag tag;
    } t_line;

    t_line mem [SETS][WAYS];
    t_line r_rd [WAYS];
    t_set r_clr;
    logic [1:0] r_st;
    t_req r_req;
    logic [PEN_W-1:0] r_pen;
    logic [CNT_W-1:0] r_tot, r_rh, r_rm, r_wh, r_wm, r_wb, r_ev;
    t_line rd_eff [WAYS];
    t_line wr_line [WAYS];
    logic hit, vv, vd;
    t_way way, old_age;
    logic [COST_W-1:0] cost;

    assign o_req_ready = (r_st == ST_IDLE);
    assign cfg_ch.ready = 1'b1;

    always_comb begin
        hit = 1'b0;
        way = '0;
        for (int w = WAYS-1; w >= 0; w--) begin
            rd_eff[w] = r_rd[w];
        end
        for (int w = WAYS-1; w >= 0; w--) begin
            if (rd_eff[w].valid && rd_eff[w].tag == r_req.tag) begin
                hit = 1'b1;
                way = t_way'(w);
            end
        end
        if (!hit) begin
            for (int w = 0; w < WAYS; w++) begin
                if (rd_eff[w].age == '0) way = t_way'(w);
            end
        end
        vv = !hit && rd_eff[way].valid;
        vd = vv && rd_eff[way].dirty;
        cost = 11'd1 + (hit ? 11'd0 : COST_W'(r_pen)) + (vd ? COST_W'(r_pen) : 11'd0);
        old_age = rd_eff[way].age;
        for (int w = 0; w < WAYS; w++) begin
            wr_line[w] = rd_eff[w];
            if (rd_eff[w].age > old_age) wr_line[w].age = rd_eff[w].age - 1'b1;
        end
        wr_line[way].age = t_way'(WAYS-1);
        wr_line[way].valid = 1'b1;
        if (hit) begin
            wr_line[way].dirty = rd_eff[way].dirty | r_req.is_write;
        end else begin
            wr_line[way].dirty = r_req.is_write;
            wr_line[way].tag = r_req.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
            for (int w = 0; w < WAYS; w++) r_rd[w] <= mem[i_req.set_idx][w];
        end
        if (r_st == ST_CLEAR) begin
            for (int w = 0; w < WAYS; w++) begin
                mem[r_clr][w] <= t_line'{valid: 1'b0, dirty: 1'b0, age: t_way'(w), tag: '0};
            end
        end
        if (r_st == ST_LOOK) begin
            for (int w = 0; w < WAYS; w++) mem[r_req.set_idx][w] <= wr_line[w];
            out_ch.hit <= hit;
            out_ch.way <= 2'(way);
            out_ch.victim_dirty <= vd;
            out_ch.victim_valid <= vv;
            out_ch.access_cycles <= cost;
        end
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_clr <= '0;
            r_pen <= PENALTY_RESET;
            {r_tot, r_rh, r_rm, r_wh, r_wm, r_wb, r_ev} <= '0;
        end else begin
            if (cfg_ch.valid) r_pen <= cfg_ch.data;
            case (r_st)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == t_set'(SETS-1)) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_req_valid) r_st <= ST_LOOK;
                end
                ST_LOOK: begin
                    r_tot <= sat_inc(r_tot, cost);
                    if (hit && !r_req.is_write) r_rh <= sat_inc(r_rh, 11'd1);
                    if (!hit && !r_req.is_write) r_rm <= sat_inc(r_rm, 11'd1);
                    if (hit && r_req.is_write) r_wh <= sat_inc(r_wh, 11'd1);
                    if (!hit && r_req.is_write) r_wm <= sat_inc(r_wm, 11'd1);
                    if (vd) r_wb <= sat_inc(r_wb, 11'd1);
                    if (vv) r_ev <= sat_inc(r_ev, 11'd1);
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_ch.ready) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid = (r_st == ST_OUT);
    assign out_ch.total_cycles = r_tot;
    assign out_ch.read_hit_count = r_rh;
    assign out_ch.read_miss_count = r_rm;
    assign out_ch.write_hit_count = r_wh;
    assign out_ch.write_miss_count = r_wm;
    assign out_ch.writeback_count = r_wb;
    assign out_ch.eviction_count = r_ev;
endmodule

>>> design/set_assoc_lru_cache_tag_model.sv
`timescale 1ns / 1ps
// Tag model of a 4-way, 1024-set, 32-byte-line write-back write-allocate LRU cache.
// Each access passes the lookup unit in steps (set read, compare and update,
// result), a read-modify-write of the tag memory, and the result holds until taken;
// a two-entry queue in front keeps taking accesses meanwhile until it is full.
// After reset a clearing pass over all 1024 sets, one set per cycle, writes the reset
// state into the tag memory; accesses wait in the queue until it ends. The penalty
// register resets to 50 and may be written whenever the block is idle.
module set_assoc_lru_cache_tag_model
    import salc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    salc_in_if.sink    in_ch,
    salc_cfg_if.sink   cfg_ch,
    salc_out_if.source out_ch
);
    logic req_valid, req_ready;
    t_req req;

    salc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_req_valid(req_valid), .o_req(req), .i_req_ready(req_ready)
    );

    salc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req_valid), .i_req(req),
        .o_req_ready(req_ready), .cfg_ch(cfg_ch), .out_ch(out_ch)
    );
endmodule
